// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; the including module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

// File: sv/pcvm_pkg.sv
// Package for the voxel mean unit: constants, payload structs, register codes.
// Depends on nothing.
package pcvm_pkg;
   localparam int GRID_X_DEF = 16;
   localparam int GRID_Y_DEF = 16;
   localparam int GRID_Z_DEF = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_POINTS = 3'd6;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic               operation;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic [15:0]        intensity;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [3:0]         cell_x;
      logic [3:0]         cell_y;
      logic [1:0]         cell_z;
      logic signed [23:0] mean_x;
      logic signed [23:0] mean_y;
      logic signed [23:0] mean_z;
      logic [15:0]        mean_intensity;
      logic [7:0]         point_count;
      logic               last;
   } rsp_type;
endpackage

// File: sv/point_cloud_voxel_mean_unit.sv
// Voxel mean unit. An add holds the input while three index divisions share one serial
// divider, then reads and writes back the cell; a dropped point skips the read and write.
// A fetch scans on from where the last fetch stopped, returns the next cell whose count is
// nonzero and within the point limit after four mean divisions, and past the final cell
// gives the end marker and clears the store. Output waits while a prior result stalls.
// Reset clears registers and then sweeps the store the same way, with no transfer accepted.
module point_cloud_voxel_mean_unit #(
   parameter int GRID_X = pcvm_pkg::GRID_X_DEF,
   parameter int GRID_Y = pcvm_pkg::GRID_Y_DEF,
   parameter int GRID_Z = pcvm_pkg::GRID_Z_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pcvm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pcvm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [pcvm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcvm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pcvm_pkg::*;

   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW = $clog2(CELLS + 1);
   localparam int SW = 32 + 32 + 32 + 24 + 8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_DIVZ, S_READ, S_WRITE,
      S_SCAN, S_SCHK, S_MX, S_MY, S_MZ, S_MI, S_OUT
   } state_type;

   state_type state_ff;
   logic signed [23:0] min_x_ff, min_y_ff, min_z_ff;
   logic [22:0] size_x_ff, size_y_ff, size_z_ff;
   logic [7:0]  maxp_ff;
   req_type     req_ff;
   logic [CW-1:0] cur_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] cell_ff;
   logic [9:0]  pos_x_ff, pos_y_ff;
   logic [7:0]  pos_z_ff;
   logic [31:0] ix_ff, iy_ff;
   logic        drop_ff, divgo_ff, divgo_in;
   logic [31:0] mx_ff, my_ff, mz_ff;
   logic [15:0] mi_ff;
   rsp_type     rsp_ff, rsp_end;
   logic        rsp_valid_ff, rsp_free, rsp_load, cell_hit;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [SW-1:0] wr_data, rd_data;
   logic [31:0]   sx, sy, sz;
   logic [23:0]   si;
   logic [7:0]    sc;

   logic          div_start, div_done;
   logic [31:0]   div_num, div_q;
   logic [23:0]   div_den;

   logic signed [24:0] dx, dy, dz;
   logic [24:0] mag_x, mag_y, mag_z;
   logic [31:0] sum_mag;

   assign {sx, sy, sz, si, sc} = rd_data;
   assign dx = 25'(req_ff.point_x) - 25'(min_x_ff);
   assign dy = 25'(req_ff.point_y) - 25'(min_y_ff);
   assign dz = 25'(req_ff.point_z) - 25'(min_z_ff);
   assign mag_x = dx[24] ? 25'(-dx) : 25'(dx);
   assign mag_y = dy[24] ? 25'(-dy) : 25'(dy);
   assign mag_z = dz[24] ? 25'(-dz) : 25'(dz);
   assign cell_hit = (sc != 8'd0) && (sc <= maxp_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = rsp_free && ((state_ff == S_SCAN && 32'(cur_ff) >= CELLS)
                                  || state_ff == S_OUT);

   pcvm_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   pcvm_div #(.NW(32), .DW(24)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      rsp_end = '0;
      rsp_end.last = 1'b1;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = cell_ff;
      wr_data = {sx + 32'(req_ff.point_x), sy + 32'(req_ff.point_y),
                 sz + 32'(req_ff.point_z), si + 24'(req_ff.intensity), sc + 8'd1};
      rd_addr = cell_ff;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == S_WRITE) begin
         wr_en = (sc != 8'hff);
      end
      if (state_ff == S_SCAN) begin
         rd_addr = cur_ff[AW-1:0];
      end
   end

   always_comb begin
      divgo_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            divgo_in = req_valid && !req_stall && req_data.operation == OP_ADD;
         end
         S_DIVX, S_DIVY, S_MX, S_MY, S_MZ: begin
            divgo_in = div_done;
         end
         S_SCHK: begin
            divgo_in = cell_hit;
         end
         default: begin
            divgo_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      div_start = divgo_ff;
      div_num = '0;
      div_den = '0;
      sum_mag = '0;
      case (state_ff)
         S_DIVX: begin
            div_num = 32'(mag_x);
            div_den = {1'b0, size_x_ff};
         end
         S_DIVY: begin
            div_num = 32'(mag_y);
            div_den = {1'b0, size_y_ff};
         end
         S_DIVZ: begin
            div_num = 32'(mag_z);
            div_den = {1'b0, size_z_ff};
         end
         S_MX: begin
            sum_mag = sx[31] ? -sx : sx;
            div_num = sum_mag;
            div_den = 24'(sc);
         end
         S_MY: begin
            sum_mag = sy[31] ? -sy : sy;
            div_num = sum_mag;
            div_den = 24'(sc);
         end
         S_MZ: begin
            sum_mag = sz[31] ? -sz : sz;
            div_num = sum_mag;
            div_den = 24'(sc);
         end
         S_MI: begin
            div_num = 32'(si);
            div_den = 24'(sc);
         end
         default: begin
            div_num = '0;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cur_ff <= '0;
         divgo_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_x_ff <= '0;
         min_y_ff <= '0;
         min_z_ff <= '0;
         size_x_ff <= 23'd1024;
         size_y_ff <= 23'd1024;
         size_z_ff <= 23'd1024;
         maxp_ff <= 8'd32;
      end else begin
         divgo_ff <= divgo_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               REG_MIN_X: min_x_ff <= csr_data;
               REG_MIN_Y: min_y_ff <= csr_data;
               REG_MIN_Z: min_z_ff <= csr_data;
               REG_SIZE_X: size_x_ff <= csr_data[22:0];
               REG_SIZE_Y: size_y_ff <= csr_data[22:0];
               REG_SIZE_Z: size_z_ff <= csr_data[22:0];
               REG_MAX_POINTS: maxp_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == CELLS - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  if (req_data.operation == OP_FETCH) begin
                     state_ff <= S_SCAN;
                  end else begin
                     drop_ff <= 1'b0;
                     state_ff <= S_DIVX;
                  end
               end
            end
            S_DIVX, S_DIVY, S_DIVZ: begin
               if (div_done) begin
                  if (state_ff == S_DIVX) begin
                     ix_ff <= div_q;
                     drop_ff <= size_x_ff == '0 || div_q >= 32'(GRID_X)
                                || (dx[24] && div_q != '0);
                     state_ff <= S_DIVY;
                  end else if (state_ff == S_DIVY) begin
                     iy_ff <= div_q;
                     drop_ff <= drop_ff || size_y_ff == '0 || div_q >= 32'(GRID_Y)
                                || (dy[24] && div_q != '0);
                     state_ff <= S_DIVZ;
                  end else begin
                     if (drop_ff || size_z_ff == '0 || div_q >= 32'(GRID_Z)
                         || (dz[24] && div_q != '0)) begin
                        state_ff <= S_IDLE;
                     end else begin
                        cell_ff <= AW'((ix_ff * GRID_Y + iy_ff) * GRID_Z + div_q);
                        state_ff <= S_READ;
                     end
                  end
               end
            end
            S_READ: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               if (32'(cur_ff) >= CELLS) begin
                  if (rsp_free) begin
                     rsp_ff <= rsp_end;
                     cur_ff <= '0;
                     clr_ff <= '0;
                     state_ff <= S_CLEAR;
                  end
               end else begin
                  cell_ff <= cur_ff[AW-1:0];
                  cur_ff <= cur_ff + 1'b1;
                  if (cur_ff == '0) begin
                     pos_x_ff <= '0;
                     pos_y_ff <= '0;
                     pos_z_ff <= '0;
                  end else if (pos_z_ff == 8'(GRID_Z - 1)) begin
                     pos_z_ff <= '0;
                     if (pos_y_ff == 10'(GRID_Y - 1)) begin
                        pos_y_ff <= '0;
                        pos_x_ff <= pos_x_ff + 1'b1;
                     end else begin
                        pos_y_ff <= pos_y_ff + 1'b1;
                     end
                  end else begin
                     pos_z_ff <= pos_z_ff + 1'b1;
                  end
                  state_ff <= S_SCHK;
               end
            end
            S_SCHK: begin
               if (cell_hit) begin
                  state_ff <= S_MX;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_MX, S_MY, S_MZ, S_MI: begin
               if (div_done) begin
                  case (state_ff)
                     S_MX: begin
                        mx_ff <= sx[31] ? -div_q : div_q;
                        state_ff <= S_MY;
                     end
                     S_MY: begin
                        my_ff <= sy[31] ? -div_q : div_q;
                        state_ff <= S_MZ;
                     end
                     S_MZ: begin
                        mz_ff <= sz[31] ? -div_q : div_q;
                        state_ff <= S_MI;
                     end
                     default: begin
                        mi_ff <= div_q[15:0];
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_ff.found <= 1'b1;
                  rsp_ff.cell_x <= 4'(pos_x_ff);
                  rsp_ff.cell_y <= 4'(pos_y_ff);
                  rsp_ff.cell_z <= 2'(pos_z_ff);
                  rsp_ff.mean_x <= mx_ff[23:0];
                  rsp_ff.mean_y <= my_ff[23:0];
                  rsp_ff.mean_z <= mz_ff[23:0];
                  rsp_ff.mean_intensity <= mi_ff;
                  rsp_ff.point_count <= sc;
                  rsp_ff.last <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// File: sv/pcvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module pcvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: sv/pcvm_div.sv
// Iterative restoring divider: unsigned dividend over unsigned divisor, one bit a cycle.
// Depends on nothing.
module pcvm_div #(
   parameter int NW = 32,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end
   assign done = done_ff;
   assign quotient = q_ff;
endmodule

// File: sv/pcvm_checker.sv
// Port-level checker for the voxel mean unit, bound to the top level.
// Depends on pcvm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcvm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pcvm_pkg::rsp_type rsp_data
);
   import pcvm_pkg::*;
   logic rsp_held, req_taken;
   assign rsp_held = rsp_valid && rsp_stall;
   assign req_taken = req_valid && !req_stall;
   `ASSERT_CLK(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_data), "held result changed")
   `ASSERT_CLK(a_found_last, rsp_valid |-> !(rsp_data.found && rsp_data.last), "found with last")
   `ASSERT_CLK(a_busy_after_take, req_taken |=> req_stall, "input open after a transfer")
   `ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "result valid after reset")
endmodule

bind point_cloud_voxel_mean_unit pcvm_checker u_pcvm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
